>>> rtl/core/nzl_pkg.sv
// Nonzero element locator: shared types and constants.
// No dependencies; imported by every module of the block except nzl_checker.
package nzl_pkg;

  localparam int unsigned MaxChannels = 4;
  localparam int unsigned CapW        = 7;   // holds a flush count up to 64

  // configuration register indexes
  localparam logic [2:0] CfgRowLength     = 3'd0;
  localparam logic [2:0] CfgChannelCount  = 3'd1;
  localparam logic [2:0] CfgMaxMatches    = 3'd2;
  localparam logic [2:0] CfgScanDirection = 3'd3;
  localparam logic [2:0] CfgElementKind   = 3'd4;

  // element kinds
  localparam logic [1:0] KindFloat32 = 2'd1;
  localparam logic [1:0] KindFloat64 = 2'd2;

  // one result, linear index in the lowest bits
  typedef struct packed {
    logic [63:0] matched_value;
    logic [1:0]  channel_index;
    logic [15:0] column_index;
    logic [15:0] row_index;
    logic [31:0] linear_index;
  } nzl_res_t;

  // request from the front to the back
  typedef struct packed {
    logic            emit;   // send res now as the only result
    logic            store;  // push res into the recent-match memory
    logic            flush;  // frame end: read back up to cap entries and clear the store
    logic [CapW-1:0] cap;    // min(max_matches, store depth); zero outside last-N mode
    nzl_res_t        res;
  } nzl_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } nzl_bk_state_e;

endpackage

>>> rtl/core/nzl_front.sv
// Front end: configuration registers, position counters and zero test.
// Classifies each element into a request for the back end. Uses nzl_pkg.
module nzl_front #(
  parameter int unsigned RECENT_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        in_value_i,
  input  logic               in_last_i,
  output logic               req_valid_o,
  input  logic               req_ready_i,
  output nzl_pkg::nzl_cmd_t  req_o
);
  import nzl_pkg::*;

  logic [15:0] row_length_q;
  logic [2:0]  channel_count_q;
  logic [23:0] max_matches_q;
  logic        scan_direction_q;
  logic [1:0]  element_kind_q;

  logic [31:0] elem_q, elem_d;
  logic [15:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [1:0]  chan_q, chan_d;
  logic [23:0] emitted_q, emitted_d;

  logic        accept, nonzero, last_mode, emit, store, flush;
  logic [2:0]  nch;
  logic [15:0] rl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q     <= 16'd1;
      channel_count_q  <= 3'd1;
      max_matches_q    <= '0;
      scan_direction_q <= 1'b0;
      element_kind_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRowLength:     row_length_q     <= cfg_data_i[15:0];
        CfgChannelCount:  channel_count_q  <= cfg_data_i[2:0];
        CfgMaxMatches:    max_matches_q    <= cfg_data_i;
        CfgScanDirection: scan_direction_q <= cfg_data_i[0];
        CfgElementKind:   element_kind_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = req_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last_mode  = scan_direction_q && (max_matches_q != '0);

  always_comb begin
    case (element_kind_q)
      KindFloat32: nonzero = in_value_i[30:0] != '0;
      KindFloat64: nonzero = in_value_i[62:0] != '0;
      default:     nonzero = in_value_i != '0;
    endcase
  end

  assign emit  = nonzero && !last_mode &&
                 ((max_matches_q == '0) || (emitted_q < max_matches_q));
  assign store = nonzero && last_mode;
  assign flush = in_last_i;

  always_comb begin
    nch = channel_count_q;
    if (nch == 3'd0) nch = 3'd1;
    if (nch > 3'(MaxChannels)) nch = 3'(MaxChannels);
    rl = (row_length_q == '0) ? 16'd1 : row_length_q;
  end

  always_comb begin
    elem_d    = elem_q + 32'd1;
    row_d     = row_q;
    col_d     = col_q;
    chan_d    = chan_q;
    emitted_d = emitted_q;
    if (emit && (emitted_q != 24'hFF_FFFF)) emitted_d = emitted_q + 24'd1;
    if (({1'b0, chan_q} + 3'd1) >= nch) begin
      chan_d = '0;
      if (({1'b0, col_q} + 17'd1) >= {1'b0, rl}) begin
        col_d = '0;
        row_d = row_q + 16'd1;
      end else begin
        col_d = col_q + 16'd1;
      end
    end else begin
      chan_d = chan_q + 2'd1;
    end
    if (in_last_i) begin
      elem_d    = '0;
      row_d     = '0;
      col_d     = '0;
      chan_d    = '0;
      emitted_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      chan_q    <= '0;
      emitted_q <= '0;
    end else if (accept) begin
      elem_q    <= elem_d;
      row_q     <= row_d;
      col_q     <= col_d;
      chan_q    <= chan_d;
      emitted_q <= emitted_d;
    end
  end

  assign req_valid_o = accept && (emit || store || flush);

  always_comb begin
    req_o.emit  = emit;
    req_o.store = store;
    req_o.flush = flush;
    req_o.cap   = '0;
    if (last_mode) begin
      req_o.cap = (max_matches_q < 24'(RECENT_DEPTH)) ? max_matches_q[CapW-1:0]
                                                      : CapW'(RECENT_DEPTH);
    end
    req_o.res.linear_index  = elem_q;
    req_o.res.row_index     = row_q;
    req_o.res.column_index  = col_q;
    req_o.res.channel_index = chan_q;
    req_o.res.matched_value = in_value_i;
  end

endmodule

>>> rtl/core/nzl_queue.sv
// Two-entry request queue between front and back end.
// Uses nzl_pkg for the request type.
module nzl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  nzl_pkg::nzl_cmd_t  wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output nzl_pkg::nzl_cmd_t  rd_data_o
);
  import nzl_pkg::*;

  nzl_cmd_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = count_q != 2'd2;
  assign rd_valid_o = count_q != 2'd0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/nzl_back.sv
// Back end: recent-match memory, last-N flush sequencer and output register.
// Uses nzl_pkg for request, result and state types.
module nzl_back #(
  parameter int unsigned RECENT_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  nzl_pkg::nzl_cmd_t  req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output nzl_pkg::nzl_res_t  out_res_o,
  output logic               out_last_o
);
  import nzl_pkg::*;

  localparam int unsigned AW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RECENT_DEPTH + 1);

  nzl_res_t      mem [RECENT_DEPTH];
  nzl_res_t      rd_q;
  nzl_bk_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, head_nx, ptr_q, ptr_d;
  logic [CW-1:0] fill_q, fill_d, fill_nx, cnt_q, cnt_d, cap;
  logic          out_valid_q, out_valid_d, out_last_q, out_last_d;
  nzl_res_t      out_res_q, out_res_d;
  logic          out_free, pop, wr_en;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = req_valid_i && req_ready_o;
  assign wr_en    = pop && req_i.store;
  assign cap      = CW'(req_i.cap);

  always_comb begin
    head_nx = head_q;
    fill_nx = fill_q;
    if (req_i.store) begin
      head_nx = (head_q == AW'(RECENT_DEPTH - 1)) ? '0 : head_q + 1'b1;
      if (fill_q < CW'(RECENT_DEPTH)) fill_nx = fill_q + 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_last_d  = out_last_q;
    req_ready_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        req_ready_o = out_free;
        if (pop) begin
          head_d = head_nx;
          fill_d = fill_nx;
          if (req_i.emit) begin
            out_valid_d = 1'b1;
            out_res_d   = req_i.res;
            out_last_d  = 1'b1;
          end
          if (req_i.flush) begin
            head_d = '0;
            fill_d = '0;
            cnt_d  = (fill_nx < cap) ? fill_nx : cap;
            ptr_d  = (head_nx == '0) ? AW'(RECENT_DEPTH - 1) : head_nx - 1'b1;
            if (cnt_d != '0) state_d = BK_READ;
          end
        end
      end
      BK_READ: state_d = BK_LOAD;
      BK_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = rd_q;
          out_last_d  = cnt_q == CW'(1);
          cnt_d       = cnt_q - 1'b1;
          ptr_d       = (ptr_q == '0) ? AW'(RECENT_DEPTH - 1) : ptr_q - 1'b1;
          state_d     = (cnt_q == CW'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[head_q] <= req_i.res;
    rd_q      <= mem[ptr_q];
    out_res_q <= out_res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/core/nonzero_element_locator.sv
// Nonzero element locator, top level.
// Instantiates nzl_front, nzl_queue and nzl_back; uses nzl_pkg.
//
// Takes one image element per cycle in raster, pixel-interleaved order while the
// two-entry request queue has room, and reports each nonzero element with its
// linear index, row, column and channel subscripts and raw bits; tlast on the input
// marks the frame end, tlast on the output the final result of a run.
// In first-N mode (or with no limit) a match passes through the request queue into the
// output register. In last-N mode matches go into a RECENT_DEPTH-entry memory; at
// frame end up to max_matches of them are read back newest first, each via the
// BK_READ and BK_LOAD states (registered memory read); no request is taken until the
// readback ends, and the input stalls once the queue is full. Configuration writes
// take effect at once; the user must make them with the block idle (not enforced).
module nonzero_element_locator #(
  parameter int unsigned RECENT_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // element_value
  input  logic          s_axis_tlast,   // frame_end
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // linear_index, row_index, column_index, channel_index, matched_value, zero pad
  output logic [135:0]  m_axis_tdata,
  output logic          m_axis_tlast    // run_last
);
  import nzl_pkg::*;

  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  nzl_cmd_t fq_cmd, qb_cmd;
  nzl_res_t out_res;

  nzl_front #(
    .RECENT_DEPTH(RECENT_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .req_valid_o(fq_valid),
    .req_ready_i(fq_ready),
    .req_o      (fq_cmd)
  );

  nzl_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_ready_o(fq_ready),
    .wr_data_i (fq_cmd),
    .rd_valid_o(qb_valid),
    .rd_ready_i(qb_ready),
    .rd_data_o (qb_cmd)
  );

  nzl_back #(
    .RECENT_DEPTH(RECENT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(qb_valid),
    .req_ready_o(qb_ready),
    .req_i      (qb_cmd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (out_res),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_res};

endmodule

>>> rtl/core/nzl_checker.sv
// Port-level checks for nonzero_element_locator, with the bind that attaches them.
// No package dependency.
module nzl_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // no result straight after a reset cycle
  a_quiet_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result presented during reset");

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // every reported value has a nonzero bit pattern, including those read back from the store
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[129:66] != 64'd0)
    else $error("zero value reported");

  // padding stays clear
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[135:130] == 6'd0)
    else $error("tdata padding not zero");

endmodule

bind nonzero_element_locator nzl_checker u_nzl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
